FILE: rtl/assert_macros.svh
// Assertion macros of the multi-press classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bmpc_pkg.sv
// Types and constants of the button multi-press classifier.
package bmpc_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_EN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIPLE_EN    = 3'd5;

  // Reset values of the timing registers
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] MULTI_WINDOW_RST = 16'd400;

  typedef logic [1:0] count_t;

  typedef enum logic [2:0] {
    G_NONE   = 3'd0,
    G_SINGLE = 3'd1,
    G_DOUBLE = 3'd2,
    G_TRIPLE = 3'd3,
    G_LONG   = 3'd4
  } gesture_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_PRESSING = 4'b0010,
    ST_WAITING  = 4'b0100,
    ST_LONG     = 4'b1000
  } state_t;

  // Outcome of one pass of the press state machine
  typedef struct packed {
    state_t   state;
    count_t   count;
    gesture_t gesture;
    logic     set_start;
    logic     set_release;
  } run_t;

endpackage

FILE: rtl/bmpc_in_if.sv
// Sample channel of the multi-press classifier: valid, ready and the raw level.
interface bmpc_in_if;
  logic valid;
  logic ready;
  logic pressed_sample;

  modport source (output valid, output pressed_sample, input ready);
  modport sink (input valid, input pressed_sample, output ready);
endinterface

FILE: rtl/bmpc_out_if.sv
// Result channel of the multi-press classifier: valid, ready and the report.
interface bmpc_out_if;
  import bmpc_pkg::*;

  logic     valid;
  logic     ready;
  gesture_t gesture;
  logic     debounced_pressed;
  count_t   presses_counted;

  modport source (output valid, output gesture, output debounced_pressed,
                  output presses_counted, input ready);
  modport sink (input valid, input gesture, input debounced_pressed,
                input presses_counted, output ready);
endinterface

FILE: rtl/button_multi_press_classifier.sv
// Button multi-press classifier: debounce, press state machine and result register.
//
// Each sample transfer is one poll tick and yields exactly one result transfer;
// the result is registered and offered from the next cycle. The whole tick (clock
// advance, debounce check, the edge pass and the timeout pass of the press state
// machine) is evaluated combinationally between the state registers and the result register, so a new sample is
// taken in every cycle as long as the result register is empty or is being
// drained in that cycle; a stalled result holds in the result register and
// blocks only the next sample. Gesture codes: 0 none, 1 single, 2 double,
// 3 triple, 4 long press. Times wrap at TIME_WIDTH bits. Configuration is
// written through cfg_we/cfg_index/cfg_wdata; indexes beyond the last
// register are ignored.
module button_multi_press_classifier #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bmpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  bmpc_in_if.sink                             in_ch,
  bmpc_out_if.source                          out_ch
);
  import bmpc_pkg::*;

  `include "assert_macros.svh"

  typedef logic [TIME_WIDTH-1:0] time_t;

  // Configuration registers
  logic [CFG_DATA_W-1:0] debounce_r, long_press_r, multi_window_r;
  logic                  single_en_r, double_en_r, triple_en_r;

  // Tick state
  time_t    tick_r, start_r, release_r, edge_r;
  time_t    tick_nxt, start_nxt, release_nxt, edge_nxt;
  state_t   state_r, state_nxt;
  count_t   count_r, count_nxt;
  logic     level_r, level_nxt;

  // Result register
  logic     out_valid_r;
  gesture_t gesture_r, gesture_nxt;
  logic     out_level_r;
  count_t   out_count_r;

  logic     accept;
  logic     edge_acc;
  logic     deb_ok, long_old, win_old, long_zero;
  run_t     run_edge, run_tmo;

  // One pass of the press state machine
  function automatic run_t run_machine(input state_t st, input count_t cnt,
                                       input logic level, input logic long_hit,
                                       input logic win_hit, input logic en_s,
                                       input logic en_d, input logic en_t);
    run_t   r;
    count_t inc;
    logic   dispatch;
    r.state       = st;
    r.count       = cnt;
    r.gesture     = G_NONE;
    r.set_start   = 1'b0;
    r.set_release = 1'b0;
    inc           = (cnt == 2'd3) ? cnt : cnt + 2'd1;
    dispatch      = (inc == 2'd1 && en_s && !en_d && !en_t) ||
                    (inc == 2'd2 && en_d && !en_t) ||
                    (inc == 2'd3 && en_t);
    unique case (st)
      ST_IDLE: begin
        if (level) begin
          r.set_start = 1'b1;
          r.state     = ST_PRESSING;
        end
      end
      ST_WAITING: begin
        // a press resumes the sequence even after the window ran out
        if (level) begin
          r.set_start = 1'b1;
          r.state     = ST_PRESSING;
        end else if (win_hit) begin
          r.gesture = gesture_t'({1'b0, cnt});
          r.count   = 2'd0;
          r.state   = ST_IDLE;
        end
      end
      ST_PRESSING: begin
        if (level) begin
          // long press only on the first press of a sequence
          if (cnt == 2'd0 && long_hit) begin
            r.gesture = G_LONG;
            r.state   = ST_LONG;
          end
        end else begin
          r.set_release = 1'b1;
          if (dispatch) begin
            r.gesture = gesture_t'({1'b0, inc});
            r.count   = 2'd0;
            r.state   = ST_IDLE;
          end else begin
            r.count = inc;
            r.state = ST_WAITING;
          end
        end
      end
      ST_LONG: begin
        if (!level) begin
          r.count = 2'd0;
          r.state = ST_IDLE;
        end
      end
      default: r.state = ST_IDLE;
    endcase
    return r;
  endfunction

  // Take a sample while the result register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Elapsed-time compares against the state before this tick
  always_comb begin
    tick_nxt  = tick_r + time_t'(1);
    deb_ok    = (tick_nxt - edge_r) >= time_t'(debounce_r);
    long_old  = (tick_nxt - start_r) >= time_t'(long_press_r);
    win_old   = (tick_nxt - release_r) > time_t'(multi_window_r);
    long_zero = (long_press_r == '0);
    edge_acc  = (in_ch.pressed_sample != level_r) && deb_ok;
  end

  // Edge pass, then timeout pass with the debounced level
  always_comb begin
    if (edge_acc) begin
      run_edge = run_machine(state_r, count_r, in_ch.pressed_sample, long_old,
                             win_old, single_en_r, double_en_r, triple_en_r);
    end else begin
      run_edge = '{state: state_r, count: count_r, gesture: G_NONE,
                   set_start: 1'b0, set_release: 1'b0};
    end
    level_nxt = edge_acc ? in_ch.pressed_sample : level_r;
    // a time stamped in the edge pass has zero elapsed in the timeout pass
    run_tmo = run_machine(run_edge.state, run_edge.count, level_nxt,
                          run_edge.set_start ? long_zero : long_old,
                          run_edge.set_release ? 1'b0 : win_old,
                          single_en_r, double_en_r, triple_en_r);
    state_nxt   = run_tmo.state;
    count_nxt   = run_tmo.count;
    edge_nxt    = edge_acc ? tick_nxt : edge_r;
    start_nxt   = (run_edge.set_start || run_tmo.set_start) ? tick_nxt : start_r;
    release_nxt = (run_edge.set_release || run_tmo.set_release) ? tick_nxt : release_r;
    // the later report wins
    gesture_nxt = (run_tmo.gesture != G_NONE) ? run_tmo.gesture : run_edge.gesture;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= DEBOUNCE_RST;
      long_press_r   <= LONG_PRESS_RST;
      multi_window_r <= MULTI_WINDOW_RST;
      single_en_r    <= 1'b0;
      double_en_r    <= 1'b0;
      triple_en_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     debounce_r     <= cfg_wdata;
        REG_LONG_PRESS:   long_press_r   <= cfg_wdata;
        REG_MULTI_WINDOW: multi_window_r <= cfg_wdata;
        REG_SINGLE_EN:    single_en_r    <= cfg_wdata[0];
        REG_DOUBLE_EN:    double_en_r    <= cfg_wdata[0];
        REG_TRIPLE_EN:    triple_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Advance tick state on each sample transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      start_r   <= '0;
      release_r <= '0;
      edge_r    <= '0;
      state_r   <= ST_IDLE;
      count_r   <= 2'd0;
      level_r   <= 1'b0;
    end else if (accept) begin
      tick_r    <= tick_nxt;
      start_r   <= start_nxt;
      release_r <= release_nxt;
      edge_r    <= edge_nxt;
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      level_r   <= level_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      gesture_r   <= gesture_nxt;
      out_level_r <= level_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.gesture           = gesture_r;
  assign out_ch.debounced_pressed = out_level_r;
  assign out_ch.presses_counted   = out_count_r;

  // Idle always carries an empty press count
  `ASSERT_IMP(a_idle_count, clk, rst_n, state_r == ST_IDLE, count_r == 2'd0,
              "press count nonzero in idle")

  // A pending long-press report leaves the machine in long-pressed
  `ASSERT_IMP(a_long_state, clk, rst_n, out_valid_r && gesture_r == G_LONG,
              state_r == ST_LONG, "long press reported outside long state")

  // A multi-press report closes the sequence
  `ASSERT_IMP(a_multi_close, clk, rst_n,
              out_valid_r && (gesture_r == G_SINGLE || gesture_r == G_DOUBLE ||
                              gesture_r == G_TRIPLE),
              state_r == ST_IDLE && out_count_r == 2'd0,
              "press report did not close the sequence")

  // Every sample transfer advances the tick clock by one
  `ASSERT_NXT(a_tick_step, clk, rst_n, accept,
              tick_r == $past(tick_r) + time_t'(1), "tick clock did not advance")

endmodule

FILE: dv/tb_button_multi_press_classifier.sv
// Self-checking testbench for the button multi-press classifier: directed script, random gestures.
module tb_button_multi_press_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpc_pkg::*;

  localparam int unsigned PHASE_TICKS    = 40;
  localparam int unsigned SETTLE_CYCLES  = 3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RESET_ROWS     = 2;
  localparam int unsigned SCRIPT_ROWS    = 19;
  localparam int unsigned SPAN_CAP       = 40;

  typedef struct packed {
    gesture_t gesture;
    logic     pressed;
    count_t   count;
  } report_t;

  typedef struct packed {
    logic   sample;
    logic   typed;
    report_t want;
  } script_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce;
    logic [CFG_DATA_W-1:0] long_press;
    logic [CFG_DATA_W-1:0] window;
    logic                  single_en;
    logic                  double_en;
    logic                  triple_en;
  } setting_t;

  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_PATTERN,
    DRAIN_LIGHT,
    DRAIN_HEAVY
  } drain_mode_t;

  localparam report_t NO_REPORT = '{G_NONE, 1'b0, 2'd0};

  // Short timings: debounce off, long press after 3 ticks, window of 2 ticks,
  // only double dispatched at once
  localparam setting_t DIRECTED = '{16'd0, 16'd3, 16'd2, 1'b0, 1'b1, 1'b0};

  // First rows run under the reset timings (edges rejected by the debounce),
  // then a window-reported single, a late press turned into an immediate
  // double, and a long press held past its report and released
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    '{1'b1, 1'b1, '{G_NONE, 1'b0, 2'd0}},
    '{1'b0, 1'b1, '{G_NONE, 1'b0, 2'd0}},
    '{1'b1, 1'b0, NO_REPORT},
    '{1'b0, 1'b0, NO_REPORT},
    '{1'b0, 1'b0, NO_REPORT},
    '{1'b0, 1'b0, NO_REPORT},
    '{1'b0, 1'b0, NO_REPORT},
    '{1'b1, 1'b0, NO_REPORT},
    '{1'b0, 1'b0, NO_REPORT},
    '{1'b0, 1'b0, NO_REPORT},
    '{1'b0, 1'b0, NO_REPORT},
    '{1'b1, 1'b0, NO_REPORT},
    '{1'b0, 1'b0, NO_REPORT},
    '{1'b1, 1'b0, NO_REPORT},
    '{1'b1, 1'b0, NO_REPORT},
    '{1'b1, 1'b0, NO_REPORT},
    '{1'b1, 1'b0, NO_REPORT},
    '{1'b1, 1'b0, NO_REPORT},
    '{1'b0, 1'b0, NO_REPORT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bmpc_in_if  sample_ch ();
  bmpc_out_if report_ch ();

  button_multi_press_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (sample_ch),
    .out_ch    (report_ch)
  );

  always #2 clk = ~clk;

  // Classifier state mirrored by the predictor
  logic [31:0]           ticks      = '0;
  state_t                fsm        = ST_IDLE;
  count_t                presses    = '0;
  logic [31:0]           press_t0   = '0;
  logic [31:0]           release_t0 = '0;
  logic [31:0]           edge_t0    = '0;
  logic                  level_q    = 1'b0;
  logic [CFG_DATA_W-1:0] debounce_len = DEBOUNCE_RST;
  logic [CFG_DATA_W-1:0] long_len     = LONG_PRESS_RST;
  logic [CFG_DATA_W-1:0] window_len   = MULTI_WINDOW_RST;
  logic                  single_on  = 1'b0;
  logic                  double_on  = 1'b0;
  logic                  triple_on  = 1'b0;

  report_t     expected_reports [$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  int unsigned phase_ticks    = 0;

  function automatic logic [31:0] since(logic [31:0] now, logic [31:0] then);
    return now - then;
  endfunction

  function automatic int unsigned clip(logic [CFG_DATA_W-1:0] v);
    return (v > SPAN_CAP) ? SPAN_CAP : int'(v);
  endfunction

  // One pass of the press state machine at time now with level lvl
  function automatic gesture_t press_fsm_pass(logic [31:0] now, logic lvl);
    gesture_t g;
    logic     immediate;
    g = G_NONE;
    case (fsm)
      ST_IDLE, ST_WAITING: begin
        if (lvl) begin
          press_t0 = now;
          fsm      = ST_PRESSING;
        end
        if (fsm == ST_WAITING && since(now, release_t0) > {16'd0, window_len}) begin
          g       = gesture_t'({1'b0, presses});
          presses = '0;
          fsm     = ST_IDLE;
        end
      end
      ST_PRESSING: begin
        if (lvl) begin
          if (presses == 2'd0 && since(now, press_t0) >= {16'd0, long_len}) begin
            g   = G_LONG;
            fsm = ST_LONG;
          end
        end else begin
          if (presses != 2'd3) presses = presses + 2'd1;
          release_t0 = now;
          immediate = (presses == 2'd1 && single_on && !double_on && !triple_on) ||
                      (presses == 2'd2 && double_on && !triple_on) ||
                      (presses == 2'd3 && triple_on);
          if (immediate) begin
            g       = gesture_t'({1'b0, presses});
            presses = '0;
            fsm     = ST_IDLE;
          end else begin
            fsm = ST_WAITING;
          end
        end
      end
      default: begin
        if (!lvl) begin
          presses = '0;
          fsm     = ST_IDLE;
        end
      end
    endcase
    return g;
  endfunction

  // Advance one poll tick: debounce, edge pass, then timeout pass
  function automatic report_t classify_tick(logic smp);
    gesture_t g;
    gesture_t pass_g;
    report_t  r;
    g     = G_NONE;
    ticks = ticks + 32'd1;
    if (smp != level_q && since(ticks, edge_t0) >= {16'd0, debounce_len}) begin
      edge_t0 = ticks;
      level_q = smp;
      pass_g  = press_fsm_pass(ticks, smp);
      if (pass_g != G_NONE) g = pass_g;
    end
    pass_g = press_fsm_pass(ticks, level_q);
    if (pass_g != G_NONE) g = pass_g;
    r.gesture = g;
    r.pressed = level_q;
    r.count   = presses;
    return r;
  endfunction

  // Send one sample in bursts with random gaps; queue its expected report
  task automatic send_tick(input logic smp, input logic typed = 1'b0,
                           input report_t want = NO_REPORT);
    int unsigned gap;
    report_t     predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    sample_ch.valid          <= 1'b1;
    sample_ch.pressed_sample <= smp;
    do @(posedge clk); while (!sample_ch.ready);
    predicted = classify_tick(smp);
    expected_reports = {expected_reports, (typed ? want : predicted)};
    phase_ticks++;
  endtask

  // Stop sending and wait until every report has come back
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE:     debounce_len = data;
      REG_LONG_PRESS:   long_len     = data;
      REG_MULTI_WINDOW: window_len   = data;
      REG_SINGLE_EN:    single_on    = data[0];
      REG_DOUBLE_EN:    double_on    = data[0];
      REG_TRIPLE_EN:    triple_on    = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(REG_DEBOUNCE, s.debounce);
    write_reg(REG_LONG_PRESS, s.long_press);
    write_reg(REG_MULTI_WINDOW, s.window);
    write_reg(REG_SINGLE_EN, {15'd0, s.single_en});
    write_reg(REG_DOUBLE_EN, {15'd0, s.double_en});
    write_reg(REG_TRIPLE_EN, {15'd0, s.triple_en});
    cfg_we <= 1'b0;
  endtask

  // Hold a level long enough to pass a debounce of up to SPAN_CAP ticks, with optional bounce first
  task automatic hold_level(input logic lvl, input int unsigned n);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_tick(lvl);
        send_tick(!lvl);
      end
    end
    repeat (n + clip(debounce_len)) send_tick(lvl);
  endtask

  // One press sequence: 1 to 4 presses, some held long, some gaps past the window
  task automatic play_gesture();
    int unsigned count;
    int unsigned hold;
    int unsigned gap;
    count = $urandom_range(1, 4);
    repeat (count) begin
      hold = ($urandom_range(0, 3) == 0) ? clip(long_len) + $urandom_range(0, 4)
                                         : $urandom_range(1, clip(long_len) / 2 + 2);
      hold_level(1'b1, hold);
      gap = ($urandom_range(0, 4) == 0) ? clip(window_len) + $urandom_range(1, 3)
                                        : $urandom_range(1, clip(window_len) + 1);
      hold_level(1'b0, gap);
    end
    hold_level(1'b0, clip(window_len) + $urandom_range(2, 6));
  endtask

  function automatic setting_t random_setting();
    setting_t s;
    s.debounce   = 16'($urandom_range(0, 4));
    s.long_press = 16'($urandom_range(0, 30));
    s.window     = 16'($urandom_range(0, 12));
    s.single_en  = 1'($urandom_range(0, 1));
    s.double_en  = 1'($urandom_range(0, 1));
    s.triple_en  = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Result side: stall on a mode of its own and check each transfer
  initial begin : report_sink
    drain_mode_t mode;
    int unsigned mode_left;
    logic [7:0]  pattern;
    report_t     want;
    report_ch.ready <= 1'b0;
    mode      = DRAIN_FREE;
    mode_left = 0;
    pattern   = 8'hff;
    forever begin
      @(posedge clk);
      if (rst_n && report_ch.valid && report_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: gesture %0d pressed %0d count %0d",
                 report_ch.gesture, report_ch.debounced_pressed, report_ch.presses_counted);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          if (report_ch.gesture !== want.gesture) begin
            $error("gesture: expected %0d, got %0d", want.gesture, report_ch.gesture);
            mismatch_count++;
          end
          if (report_ch.debounced_pressed !== want.pressed) begin
            $error("debounced_pressed: expected %0d, got %0d",
                   want.pressed, report_ch.debounced_pressed);
            mismatch_count++;
          end
          if (report_ch.presses_counted !== want.count) begin
            $error("presses_counted: expected %0d, got %0d",
                   want.count, report_ch.presses_counted);
            mismatch_count++;
          end
        end
      end
      if (mode_left == 0) begin
        mode      = drain_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
        pattern   = 8'($urandom()) | 8'h01;
      end
      mode_left--;
      pattern = {pattern[6:0], pattern[7]};
      case (mode)
        DRAIN_FREE:    report_ch.ready <= 1'b1;
        DRAIN_PATTERN: report_ch.ready <= pattern[0];
        DRAIN_LIGHT:   report_ch.ready <= ($urandom_range(0, 3) != 0);
        default:       report_ch.ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // End the run when no transfer happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((sample_ch.valid && sample_ch.ready) || (report_ch.valid && report_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[button_multi_press_classifier] ERROR");
    $finish;
  end

  initial begin : stimulus
    setting_t plan [$];
    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_index                <= '0;
    cfg_wdata                <= '0;
    sample_ch.valid          <= 1'b0;
    sample_ch.pressed_sample <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed script, switching to short timings after the reset rows
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (i == RESET_ROWS) begin
        wait_idle();
        apply_setting(DIRECTED);
      end
      send_tick(SCRIPT[i].sample, SCRIPT[i].typed, SCRIPT[i].want);
    end

    // Fixed settings cover the extremes, random ones fill in the rest
    plan = {plan, setting_t'{16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0}};
    plan = {plan, setting_t'{16'd2, 16'd8, 16'd5, 1'b0, 1'b0, 1'b0}};
    plan = {plan, setting_t'{16'd1, 16'd12, 16'd6, 1'b1, 1'b1, 1'b1}};
    plan = {plan, setting_t'{16'd3, 16'd20, 16'd4, 1'b0, 1'b1, 1'b0}};
    plan = {plan, setting_t'{16'd0, 16'hffff, 16'hffff, 1'b0, 1'b0, 1'b1}};
    plan = {plan, setting_t'{16'hffff, 16'd5, 16'd3, 1'b1, 1'b0, 1'b1}};
    plan = {plan, setting_t'{16'd1, 16'd4, 16'd0, 1'b0, 1'b1, 1'b1}};
    repeat (4) plan = {plan, random_setting()};

    foreach (plan[p]) begin
      wait_idle();
      apply_setting(plan[p]);
      phase_ticks = 0;
      while (phase_ticks < PHASE_TICKS) begin
        if ($urandom_range(0, 9) < 8)
          play_gesture();
        else
          repeat ($urandom_range(1, 16)) send_tick(1'($urandom_range(0, 1)));
      end
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("[button_multi_press_classifier] OK");
    else
      $display("[button_multi_press_classifier] ERROR");
    $finish;
  end

endmodule
